### rtl/velocity_verlet_atom_update_macros.svh
// Assertion macros shared by the velocity Verlet atom update block
`ifndef VELOCITY_VERLET_ATOM_UPDATE_MACROS_SVH
`define VELOCITY_VERLET_ATOM_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VVA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define VVA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vva_pkg.sv
// Shared constants for the velocity Verlet atom update block
package vva_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   localparam int AXES = 3;

   // Reset box length in whole units
   localparam int BOX_DEF_UNITS = 100;

   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_STEP      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VELOCITY_SCALE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_SCALE     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_X          = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_Y          = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_Z          = 3'd5;

endpackage

### rtl/vva_delay.sv
// Enabled shift line that delays a payload by a fixed number of stages
module vva_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule

### rtl/vva_div.sv
// Pipelined restoring divider, one quotient bit per stage
module vva_div #(
   parameter int NUM_BITS = 49,
   parameter int DEN_BITS = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] num_i,
   input  logic [DEN_BITS-1:0] den_i,
   output logic [NUM_BITS-1:0] quo_o,
   output logic [DEN_BITS-1:0] rem_o
);

   logic [NUM_BITS-1:0] num_ff [0:NUM_BITS];
   logic [NUM_BITS-1:0] num_in [0:NUM_BITS];
   logic [NUM_BITS-1:0] quo_ff [0:NUM_BITS];
   logic [NUM_BITS-1:0] quo_in [0:NUM_BITS];
   logic [DEN_BITS-1:0] rem_ff [0:NUM_BITS];
   logic [DEN_BITS-1:0] rem_in [0:NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [0:NUM_BITS];
   logic [DEN_BITS-1:0] den_in [0:NUM_BITS];

   assign num_in[0] = num_i;
   assign den_in[0] = den_i;
   assign quo_in[0] = '0;
   assign rem_in[0] = '0;

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_step
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      logic              fits;

      // bring down the next dividend bit and try the subtract
      assign trial = {rem_ff[i], num_ff[i][NUM_BITS-1]};
      assign diff  = trial - {1'b0, den_ff[i]};
      assign fits  = trial >= {1'b0, den_ff[i]};

      assign num_in[i+1] = num_ff[i] << 1;
      assign den_in[i+1] = den_ff[i];
      assign quo_in[i+1] = {quo_ff[i][NUM_BITS-2:0], fits};
      assign rem_in[i+1] = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= NUM_BITS; k++) begin
            num_ff[k] <= num_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign quo_o = quo_ff[NUM_BITS];
   assign rem_o = rem_ff[NUM_BITS];

endmodule

### rtl/vva_fxmul.sv
// Three-stage fixed point multiply with round half away from zero and saturation
module vva_fxmul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [WORD_BITS-1:0] a_i,
   input  logic        [WORD_BITS-2:0] b_i,
   output logic signed [WORD_BITS-1:0] p_o
);

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W - 1;
   localparam logic [2*W-1:0] LIM_NEG = (2 * W)'(1) << (W - 1);
   localparam logic [2*W-1:0] LIM_POS = LIM_NEG - (2 * W)'(1);
   localparam logic [2*W-1:0] HALF    = (2 * W)'(1) << (FRAC_BITS - 1);

   logic [W-1:0]        amag_ff, amag_in;
   logic                neg1_ff, neg1_in;
   logic [W-2:0]        b_ff;
   logic [PW-1:0]       prod_ff, prod_in;
   logic                neg2_ff;
   logic signed [W-1:0] res_ff, res_in;

   logic [2*W-1:0] sum;
   logic [2*W-1:0] shifted;
   logic [2*W-1:0] lim;
   logic [2*W-1:0] mag;

   assign neg1_in = a_i[W-1];
   assign amag_in = a_i[W-1] ? W'(-a_i) : W'(a_i);
   assign prod_in = PW'(amag_ff) * PW'(b_ff);

   always_comb begin
      sum     = {1'b0, prod_ff} + HALF;
      shifted = sum >> FRAC_BITS;
      lim     = neg2_ff ? LIM_NEG : LIM_POS;
      mag     = (shifted > lim) ? lim : shifted;
      res_in  = neg2_ff ? -W'(mag) : W'(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amag_ff <= amag_in;
         neg1_ff <= neg1_in;
         b_ff    <= b_i;
         prod_ff <= prod_in;
         neg2_ff <= neg1_ff;
         res_ff  <= res_in;
      end
   end

   assign p_o = res_ff;

endmodule

### rtl/velocity_verlet_atom_update.sv
// Throughput: one transaction per cycle; the whole pipeline holds while rsp is stalled.
// Depth comes from the two bit-serial divider pipelines (force/mass and the box wrap).
// Reset: synchronous, active high; clears stage valids and loads default registers
// (time_step, velocity_scale, time_scale = 1.0, box lengths = 100.0).
`include "velocity_verlet_atom_update_macros.svh"

module velocity_verlet_atom_update #(
   parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = vva_pkg::WORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic signed [WORD_BITS-1:0]          req_pos_x,
   input  logic signed [WORD_BITS-1:0]          req_pos_y,
   input  logic signed [WORD_BITS-1:0]          req_pos_z,
   input  logic signed [WORD_BITS-1:0]          req_vel_x,
   input  logic signed [WORD_BITS-1:0]          req_vel_y,
   input  logic signed [WORD_BITS-1:0]          req_vel_z,
   input  logic signed [WORD_BITS-1:0]          req_force_x,
   input  logic signed [WORD_BITS-1:0]          req_force_y,
   input  logic signed [WORD_BITS-1:0]          req_force_z,
   input  logic        [WORD_BITS-2:0]          req_atom_mass,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [WORD_BITS-1:0]          rsp_new_pos_x,
   output logic signed [WORD_BITS-1:0]          rsp_new_pos_y,
   output logic signed [WORD_BITS-1:0]          rsp_new_pos_z,
   output logic signed [WORD_BITS-1:0]          rsp_new_vel_x,
   output logic signed [WORD_BITS-1:0]          rsp_new_vel_y,
   output logic signed [WORD_BITS-1:0]          rsp_new_vel_z,
   input  logic                                 csr_wr_en,
   input  logic [vva_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [WORD_BITS-2:0]                 csr_wr_data
);

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int CW   = W - 1;
   localparam int AX   = vva_pkg::AXES;

   // divider sizes: force/mass quotient and box wrap quotient
   localparam int NB1  = W + F + 1;
   localparam int NB2  = W + 1;
   localparam int DL1  = NB1 + 1;
   localparam int DL2  = NB2 + 1;
   localparam int ML   = 3;

   // stage times, counted from the input register
   localparam int T_Q  = DL1;
   localparam int T_S  = T_Q + 1;
   localparam int T_A  = T_S + ML;
   localparam int T_DV = T_A + ML;
   localparam int T_V  = T_DV + 1;
   localparam int T_B  = T_V + ML;
   localparam int T_DP = T_B + ML;
   localparam int T_P1 = T_DP + 1;
   localparam int T_M  = T_P1 + 1;
   localparam int T_R  = T_M + DL2;
   localparam int T_W1 = T_R + 1;
   localparam int T_W2 = T_W1 + 1;
   localparam int T_O  = T_W2 + 1;
   localparam int NSTG = T_O + 1;

   localparam logic [CW-1:0] ONE_FX  = CW'(1) << F;
   localparam logic [CW-1:0] BOX_RST = CW'(vva_pkg::BOX_DEF_UNITS) << F;
   localparam logic [NB1-1:0] QLIM_NEG = NB1'(1) << (W - 1);
   localparam logic [NB1-1:0] QLIM_POS = QLIM_NEG - NB1'(1);

   // ---------------------------------------------------------------
   // Configuration registers; user writes only while pipeline is empty, unchecked
   // ---------------------------------------------------------------
   logic [CW-1:0] ts_ff, vs_ff, tsc_ff;
   logic [CW-1:0] box_x_ff, box_y_ff, box_z_ff;
   logic [CW-1:0] box_sel [AX];

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff    <= ONE_FX;
         vs_ff    <= ONE_FX;
         tsc_ff   <= ONE_FX;
         box_x_ff <= BOX_RST;
         box_y_ff <= BOX_RST;
         box_z_ff <= BOX_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            vva_pkg::CSR_TIME_STEP:      ts_ff    <= csr_wr_data;
            vva_pkg::CSR_VELOCITY_SCALE: vs_ff    <= csr_wr_data;
            vva_pkg::CSR_TIME_SCALE:     tsc_ff   <= csr_wr_data;
            vva_pkg::CSR_BOX_X:          box_x_ff <= csr_wr_data;
            vva_pkg::CSR_BOX_Y:          box_y_ff <= csr_wr_data;
            vva_pkg::CSR_BOX_Z:          box_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign box_sel[0] = box_x_ff;
   assign box_sel[1] = box_y_ff;
   assign box_sel[2] = box_z_ff;

   // ---------------------------------------------------------------
   // Flow control: one global advance; hold every stage while the
   // output register has a transaction that is being stalled.
   // ---------------------------------------------------------------
   logic [NSTG-1:0] vld_ff, vld_in;
   logic            adv;

   assign adv       = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NSTG-1];
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------
   // Input register: common fields
   // ---------------------------------------------------------------
   logic          func0_ff, func0_in;
   logic [CW-1:0] mass0_ff, mass0_in;
   logic          func_d;

   assign func0_in = req_func;
   assign mass0_in = req_atom_mass;

   always_ff @(posedge clock) begin
      if (adv) begin
         func0_ff <= func0_in;
         mass0_ff <= mass0_in;
      end
   end

   // carry the step selector to the final select
   vva_delay #(.WIDTH(1), .DEPTH(T_W2)) u_func_dly (
      .clock (clock),
      .en    (adv),
      .din   (func0_ff),
      .dout  (func_d)
   );

   logic signed [W-1:0] pos_i   [AX];
   logic signed [W-1:0] vel_i   [AX];
   logic signed [W-1:0] force_i [AX];
   logic signed [W-1:0] pos_o   [AX];
   logic signed [W-1:0] vel_o   [AX];

   assign pos_i[0]   = req_pos_x;
   assign pos_i[1]   = req_pos_y;
   assign pos_i[2]   = req_pos_z;
   assign vel_i[0]   = req_vel_x;
   assign vel_i[1]   = req_vel_y;
   assign vel_i[2]   = req_vel_z;
   assign force_i[0] = req_force_x;
   assign force_i[1] = req_force_y;
   assign force_i[2] = req_force_z;

   assign rsp_new_pos_x = pos_o[0];
   assign rsp_new_pos_y = pos_o[1];
   assign rsp_new_pos_z = pos_o[2];
   assign rsp_new_vel_x = vel_o[0];
   assign rsp_new_vel_y = vel_o[1];
   assign rsp_new_vel_z = vel_o[2];

   // ---------------------------------------------------------------
   // One lane per axis
   // ---------------------------------------------------------------
   for (genvar j = 0; j < AX; j++) begin : g_axis
      // input register
      logic [W-1:0]        fm_ff, fm_in;
      logic                fneg_ff, fneg_in;
      logic                fzero_ff, fzero_in;
      logic signed [W-1:0] pos0_ff, pos0_in;
      logic signed [W-1:0] vel0_ff, vel0_in;

      assign fneg_in  = force_i[j][W-1];
      assign fzero_in = (force_i[j] == '0);
      assign fm_in    = force_i[j][W-1] ? W'(-force_i[j]) : W'(force_i[j]);
      assign pos0_in  = pos_i[j];
      assign vel0_in  = vel_i[j];

      always_ff @(posedge clock) begin
         if (adv) begin
            fm_ff    <= fm_in;
            fneg_ff  <= fneg_in;
            fzero_ff <= fzero_in;
            pos0_ff  <= pos0_in;
            vel0_ff  <= vel0_in;
         end
      end

      // force / mass, rounded: floor((2|f|*2^F + m) / 2m)
      logic [NB1-1:0] qnum;
      logic [W-1:0]   qden;
      logic [NB1-1:0] quo;
      logic [1:0]     fflag_d;

      assign qnum = {fm_ff, {(F + 1){1'b0}}} + NB1'(mass0_ff);
      assign qden = {mass0_ff, 1'b0};

      vva_div #(.NUM_BITS(NB1), .DEN_BITS(W)) u_qdiv (
         .clock (clock),
         .en    (adv),
         .num_i (qnum),
         .den_i (qden),
         .quo_o (quo),
         .rem_o ()
      );

      vva_delay #(.WIDTH(2), .DEPTH(T_Q)) u_fflag_dly (
         .clock (clock),
         .en    (adv),
         .din   ({fneg_ff, fzero_ff}),
         .dout  (fflag_d)
      );

      // saturate quotient and apply the force sign; zero force gives zero
      logic signed [W-1:0] qs_ff, qs_in;
      logic [NB1-1:0]      qlim;
      logic [NB1-1:0]      qmag;

      always_comb begin
         qlim  = fflag_d[1] ? QLIM_NEG : QLIM_POS;
         qmag  = (quo > qlim) ? qlim : quo;
         if (fflag_d[0]) begin
            qs_in = '0;
         end else begin
            qs_in = fflag_d[1] ? -W'(qmag) : W'(qmag);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qs_ff <= qs_in;
         end
      end

      // dv = (q * time_step) * velocity_scale
      logic signed [W-1:0] acc_a;
      logic signed [W-1:0] dv;

      vva_fxmul #(.WORD_BITS(W), .FRAC_BITS(F)) u_mul_ts (
         .clock (clock),
         .en    (adv),
         .a_i   (qs_ff),
         .b_i   (ts_ff),
         .p_o   (acc_a)
      );

      vva_fxmul #(.WORD_BITS(W), .FRAC_BITS(F)) u_mul_vs (
         .clock (clock),
         .en    (adv),
         .a_i   (acc_a),
         .b_i   (vs_ff),
         .p_o   (dv)
      );

      // new velocity, saturated add
      logic [W-1:0]        vel_d;
      logic signed [W:0]   vsum;
      logic signed [W-1:0] vnew_ff, vnew_in;

      vva_delay #(.WIDTH(W), .DEPTH(T_DV)) u_vel_dly (
         .clock (clock),
         .en    (adv),
         .din   (vel0_ff),
         .dout  (vel_d)
      );

      always_comb begin
         vsum = {vel_d[W-1], vel_d} + {dv[W-1], dv};
         if (vsum[W] != vsum[W-1]) begin
            vnew_in = vsum[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
         end else begin
            vnew_in = vsum[W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vnew_ff <= vnew_in;
         end
      end

      // dp = (time_step * v_new) * time_scale
      logic signed [W-1:0] acc_b;
      logic signed [W-1:0] dp;

      vva_fxmul #(.WORD_BITS(W), .FRAC_BITS(F)) u_mul_tp (
         .clock (clock),
         .en    (adv),
         .a_i   (vnew_ff),
         .b_i   (ts_ff),
         .p_o   (acc_b)
      );

      vva_fxmul #(.WORD_BITS(W), .FRAC_BITS(F)) u_mul_tsc (
         .clock (clock),
         .en    (adv),
         .a_i   (acc_b),
         .b_i   (tsc_ff),
         .p_o   (dp)
      );

      // advanced position, saturated add
      logic [W-1:0]        pos_d;
      logic signed [W:0]   psum;
      logic signed [W-1:0] p1_ff, p1_in;

      vva_delay #(.WIDTH(W), .DEPTH(T_DP)) u_pos_dly (
         .clock (clock),
         .en    (adv),
         .din   (pos0_ff),
         .dout  (pos_d)
      );

      always_comb begin
         psum = {pos_d[W-1], pos_d} + {dp[W-1], dp};
         if (psum[W] != psum[W-1]) begin
            p1_in = psum[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
         end else begin
            p1_in = psum[W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            p1_ff <= p1_in;
         end
      end

      // wrap: n = floor((2|p| + box) / 2box); remainder gives |p| - n*box
      logic [W-1:0]   pm_ff, pm_in;
      logic [NB2-1:0] wnum;
      logic [W-1:0]   wden;
      logic [W-1:0]   wrem;

      assign pm_in = p1_ff[W-1] ? W'(-p1_ff) : W'(p1_ff);

      always_ff @(posedge clock) begin
         if (adv) begin
            pm_ff <= pm_in;
         end
      end

      assign wnum = {pm_ff, 1'b0} + NB2'(box_sel[j]);
      assign wden = {box_sel[j], 1'b0};

      vva_div #(.NUM_BITS(NB2), .DEN_BITS(W)) u_wdiv (
         .clock (clock),
         .en    (adv),
         .num_i (wnum),
         .den_i (wden),
         .quo_o (),
         .rem_o (wrem)
      );

      // r = (rem - box) / 2, exact since rem - box is even
      logic signed [W+1:0] rdiff;
      logic signed [W:0]   r_ff, r_in;

      assign rdiff = $signed({2'b00, wrem}) - $signed({3'b000, box_sel[j]});
      assign r_in  = rdiff[W+1:1];

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff <= r_in;
         end
      end

      // restore the sign, saturate; a zero box leaves the position alone
      logic [W-1:0]        p1_d;
      logic signed [W:0]   rsgn;
      logic signed [W-1:0] wrap_ff, wrap_in;

      vva_delay #(.WIDTH(W), .DEPTH(T_W1 - T_P1)) u_p1_dly (
         .clock (clock),
         .en    (adv),
         .din   (p1_ff),
         .dout  (p1_d)
      );

      always_comb begin
         rsgn = p1_d[W-1] ? -r_ff : r_ff;
         if (box_sel[j] == '0) begin
            wrap_in = p1_d;
         end else if (rsgn[W] != rsgn[W-1]) begin
            wrap_in = rsgn[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
         end else begin
            wrap_in = rsgn[W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            wrap_ff <= wrap_in;
         end
      end

      // output register: second step passes the position through
      logic [W-1:0]        pos_d2;
      logic [W-1:0]        vnew_d;
      logic signed [W-1:0] pout_ff, pout_in;
      logic signed [W-1:0] vout_ff, vout_in;

      vva_delay #(.WIDTH(W), .DEPTH(T_W2 - T_DP)) u_pos2_dly (
         .clock (clock),
         .en    (adv),
         .din   (pos_d),
         .dout  (pos_d2)
      );

      vva_delay #(.WIDTH(W), .DEPTH(T_W2 - T_V)) u_vnew_dly (
         .clock (clock),
         .en    (adv),
         .din   (vnew_ff),
         .dout  (vnew_d)
      );

      assign pout_in = func_d ? pos_d2 : wrap_ff;
      assign vout_in = vnew_d;

      always_ff @(posedge clock) begin
         if (adv) begin
            pout_ff <= pout_in;
            vout_ff <= vout_in;
         end
      end

      assign pos_o[j] = pout_ff;
      assign vel_o[j] = vout_ff;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `VVA_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, $stable(vld_ff), "pipeline advanced while output stalled")
   `VVA_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted transaction did not enter the pipeline")
   `VVA_ASSERT_NEXT(a_no_repeat, clock, reset, rsp_valid && !rsp_stall && !vld_ff[NSTG-2], !rsp_valid, "transaction repeated at output")
   `VVA_ASSERT_SAME(a_no_stall_empty, clock, reset, !rsp_valid, !req_stall, "input stalled with an empty output register")

endmodule
